FILE: hw/rtl/v3n_pkg.sv
`default_nettype none

package v3n_pkg;

    // Field widths of the transfer.
    localparam int COORD_W = 32;
    localparam int LEN_W   = 35;
    localparam int UNIT_W  = 32;
    localparam int LANES   = 3;

    // Internal widths.
    localparam int MAG_W    = 33;          // |tip - origin| stays below 2^32
    localparam int SQ_W     = 66;          // one squared component
    localparam int SUM_W    = 66;          // sum of three squares, below 2^66
    localparam int ROOT_W   = 34;          // floor(sqrt(sum))
    localparam int ROOT_CMP = 70;          // trial term of one root step
    localparam int NUM_W    = 125;         // squared component times 2^60
    localparam int QUO_W    = 31;          // unit magnitude, bits 30 down to 0
    localparam int ACC_W    = 97;          // partial quotient times sum
    localparam int DIV_CMP  = 130;         // trial term of one quotient step
    localparam int NUM_SHIFT = 60;

    // Item tag that follows the data down the pipeline.
    typedef struct packed {
        logic              valid;
        logic              mode;
        logic [LEN_W-1:0]  given;
        logic [LANES-1:0]  neg;
        logic              zero;
    } t_meta;

    // Working set of one component in the quotient chain.
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [ACC_W-1:0] acc;
        logic [QUO_W-1:0] quo;
    } t_lane;

endpackage

`default_nettype wire

FILE: hw/rtl/v3n_front.sv
`default_nettype none

module v3n_front import v3n_pkg::*; (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_take,
    input  wire logic                          i_req_type,
    input  wire logic [LANES-1:0][COORD_W-1:0] i_origin,
    input  wire logic [LANES-1:0][COORD_W-1:0] i_tip,
    input  wire logic [LEN_W-1:0]              i_given_length,
    output t_meta                              o_meta,
    output logic [SUM_W-1:0]                   o_sum,
    output logic [LANES-1:0][NUM_W-1:0]        o_num
);

    t_meta                         r_meta1, r_meta2, r_meta3;
    logic [LANES-1:0][MAG_W-1:0]   r_mag;
    logic [LANES-1:0][SQ_W-1:0]    r_sq;
    logic [SUM_W-1:0]              r_sum;
    logic [LANES-1:0][NUM_W-1:0]   r_num;
    logic [LANES-1:0][MAG_W-1:0]   n_mag;
    logic [LANES-1:0]              n_neg;
    logic [LANES-1:0][MAG_W-1:0]   v_diff;

    // Difference vector, split into sign and magnitude.
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            v_diff[i] = {i_tip[i][COORD_W-1], i_tip[i]}
                      - {i_origin[i][COORD_W-1], i_origin[i]};
            n_neg[i]  = v_diff[i][MAG_W-1];
            n_mag[i]  = n_neg[i] ? (~v_diff[i] + MAG_W'(1)) : v_diff[i];
        end
    end

    // Tag valid bits are the only control state here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta1.valid <= 1'b0;
            r_meta2.valid <= 1'b0;
            r_meta3.valid <= 1'b0;
        end else begin
            r_meta1.valid <= i_take;
            r_meta2.valid <= r_meta1.valid;
            r_meta3.valid <= r_meta2.valid;
        end
    end

    // Stage one: difference; stage two: squares; stage three: sum and numerators.
    always_ff @(posedge i_clk) begin
        r_meta1.mode  <= i_req_type;
        r_meta1.given <= i_given_length;
        r_meta1.neg   <= n_neg;
        r_meta1.zero  <= 1'b0;
        r_mag         <= n_mag;

        r_meta2.mode  <= r_meta1.mode;
        r_meta2.given <= r_meta1.given;
        r_meta2.neg   <= r_meta1.neg;
        r_meta2.zero  <= ~(|r_mag);
        for (int i = 0; i < LANES; i++) begin
            r_sq[i] <= SQ_W'(r_mag[i]) * SQ_W'(r_mag[i]);
        end

        r_meta3.mode  <= r_meta2.mode;
        r_meta3.given <= r_meta2.given;
        r_meta3.neg   <= r_meta2.neg;
        r_meta3.zero  <= r_meta2.zero;
        r_sum         <= r_sq[0] + r_sq[1] + r_sq[2];
        for (int i = 0; i < LANES; i++) begin
            r_num[i] <= NUM_W'(r_sq[i]) << NUM_SHIFT;
        end
    end

    assign o_meta = r_meta3;
    assign o_sum  = r_sum;
    assign o_num  = r_num;

endmodule

`default_nettype wire

FILE: hw/rtl/v3n_root_cell.sv
`default_nettype none

module v3n_root_cell import v3n_pkg::*; #(
    parameter int BIT = 0
) (
    input  wire logic              i_clk,
    input  wire logic [SUM_W-1:0]  i_rem,
    input  wire logic [ROOT_W-1:0] i_root,
    output logic [SUM_W-1:0]       o_rem,
    output logic [ROOT_W-1:0]      o_root
);

    logic [ROOT_CMP-1:0] v_trial;
    logic                v_take;

    // One root bit: keep it when (2r + 2^b) * 2^b fits in the remainder.
    always_comb begin
        v_trial = (ROOT_CMP'(i_root) << (BIT + 1)) | (ROOT_CMP'(1) << (2 * BIT));
        v_take  = v_trial <= ROOT_CMP'(i_rem);
    end

    always_ff @(posedge i_clk) begin
        o_rem  <= v_take ? (i_rem - SUM_W'(v_trial)) : i_rem;
        o_root <= v_take ? (i_root | (ROOT_W'(1) << BIT)) : i_root;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/v3n_div_cell.sv
`default_nettype none

module v3n_div_cell import v3n_pkg::*; #(
    parameter int BIT = 0
) (
    input  wire logic               i_clk,
    input  wire logic [SUM_W-1:0]   i_sum,
    input  wire t_lane [LANES-1:0]  i_lane,
    output logic [SUM_W-1:0]        o_sum,
    output t_lane [LANES-1:0]       o_lane
);

    logic [LANES-1:0][DIV_CMP-1:0] v_trial;
    logic [LANES-1:0]              v_take;
    t_lane [LANES-1:0]             n_lane;

    // One quotient bit per lane: q^2 * s grows by 2^(b+1) q s + 2^(2b) s.
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            v_trial[i] = (DIV_CMP'(i_lane[i].acc) << (BIT + 1))
                       + (DIV_CMP'(i_sum) << (2 * BIT));
            v_take[i]  = v_trial[i] <= DIV_CMP'(i_lane[i].rem);
            n_lane[i]  = i_lane[i];
            if (v_take[i]) begin
                n_lane[i].rem = i_lane[i].rem - NUM_W'(v_trial[i]);
                n_lane[i].acc = i_lane[i].acc + ACC_W'(DIV_CMP'(i_sum) << BIT);
                n_lane[i].quo = i_lane[i].quo | (QUO_W'(1) << BIT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_sum  <= i_sum;
        o_lane <= n_lane;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/vector3_normalize.sv
`default_nettype none

// Three-component vector normalizer.
// A transfer is taken at each rising edge with start high and busy low. The item
// carries an origin and a tip point (signed Q16.16) and a mode bit; the block
// forms tip - origin, its length floor(sqrt(dx^2+dy^2+dz^2)) in Q18.16 and the
// unit direction in Q1.30, truncated toward zero. In mode 1 the given length is
// reported in place of the computed one. A zero difference gives a zero
// direction with o_zero_vector set.
// Each result shows on the o_ ports for one cycle with o_valid high, after its
// input transfer has passed three front stages (difference, squares, sum), a
// row of 34 root cells that settle one length bit each, and one output stage.
// The quotient cells (31, one unit bit each for all three axes) run beside the
// root cells. A new item is taken every cycle, so throughput is one per cycle.
// The receiver cannot stall; every result must be taken when it shows.
// Synchronous reset empties the pipeline; busy is high during reset and the
// cycle after it, and low from then on.

module vector3_normalize import v3n_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      i_req_type,
    input  wire logic signed [COORD_W-1:0] i_origin_x,
    input  wire logic signed [COORD_W-1:0] i_origin_y,
    input  wire logic signed [COORD_W-1:0] i_origin_z,
    input  wire logic signed [COORD_W-1:0] i_tip_x,
    input  wire logic signed [COORD_W-1:0] i_tip_y,
    input  wire logic signed [COORD_W-1:0] i_tip_z,
    input  wire logic signed [LEN_W-1:0]   i_given_length,
    output logic                           o_valid,
    output logic signed [LEN_W-1:0]        o_vec_length,
    output logic signed [UNIT_W-1:0]       o_unit_x,
    output logic signed [UNIT_W-1:0]       o_unit_y,
    output logic signed [UNIT_W-1:0]       o_unit_z,
    output logic                           o_zero_vector
);

    localparam int ALIGN = ROOT_W - QUO_W;

    logic                         r_busy;
    logic                         v_take;
    t_meta                        v_front_meta;
    logic [SUM_W-1:0]             v_front_sum;
    logic [LANES-1:0][NUM_W-1:0]  v_front_num;

    logic [SUM_W-1:0]             w_rem  [ROOT_W+1];
    logic [ROOT_W-1:0]            w_root [ROOT_W+1];
    logic [SUM_W-1:0]             w_sum  [QUO_W+1];
    t_lane [LANES-1:0]            w_lane [QUO_W+1];
    t_meta                        r_meta [ROOT_W];
    logic [LANES-1:0][QUO_W-1:0]  r_quo_dly [ALIGN];

    t_meta                        v_last;
    logic [ROOT_W-1:0]            v_root;
    logic [LANES-1:0][UNIT_W-1:0] n_unit;

    assign v_take = start && !busy;
    assign busy   = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // Difference, squares and sum of squares.
    v3n_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (v_take),
        .i_req_type     (i_req_type),
        .i_origin       ({i_origin_z, i_origin_y, i_origin_x}),
        .i_tip          ({i_tip_z, i_tip_y, i_tip_x}),
        .i_given_length (i_given_length),
        .o_meta         (v_front_meta),
        .o_sum          (v_front_sum),
        .o_num          (v_front_num)
    );

    // Root row: one length bit per cell, most significant first.
    assign w_rem[0]  = v_front_sum;
    assign w_root[0] = '0;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_root
        v3n_root_cell #(.BIT(ROOT_W - 1 - k)) u_cell (
            .i_clk  (i_clk),
            .i_rem  (w_rem[k]),
            .i_root (w_root[k]),
            .o_rem  (w_rem[k+1]),
            .o_root (w_root[k+1])
        );
    end

    // Quotient row: one unit bit per cell for all three axes.
    assign w_sum[0] = v_front_sum;
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            w_lane[0][i].rem = v_front_num[i];
            w_lane[0][i].acc = '0;
            w_lane[0][i].quo = '0;
        end
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        v3n_div_cell #(.BIT(QUO_W - 1 - k)) u_cell (
            .i_clk  (i_clk),
            .i_sum  (w_sum[k]),
            .i_lane (w_lane[k]),
            .o_sum  (w_sum[k+1]),
            .o_lane (w_lane[k+1])
        );
    end

    // Item tags follow the root row; only the valid bits are cleared by reset.
    always_ff @(posedge i_clk) begin
        r_meta[0].mode  <= v_front_meta.mode;
        r_meta[0].given <= v_front_meta.given;
        r_meta[0].neg   <= v_front_meta.neg;
        r_meta[0].zero  <= v_front_meta.zero;
        for (int k = 1; k < ROOT_W; k++) begin
            r_meta[k].mode  <= r_meta[k-1].mode;
            r_meta[k].given <= r_meta[k-1].given;
            r_meta[k].neg   <= r_meta[k-1].neg;
            r_meta[k].zero  <= r_meta[k-1].zero;
        end
        if (!i_rst_n) begin
            for (int k = 0; k < ROOT_W; k++) begin
                r_meta[k].valid <= 1'b0;
            end
        end else begin
            r_meta[0].valid <= v_front_meta.valid;
            for (int k = 1; k < ROOT_W; k++) begin
                r_meta[k].valid <= r_meta[k-1].valid;
            end
        end
    end

    // The quotient row is shorter; hold its results until the root is done.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < LANES; i++) begin
            r_quo_dly[0][i] <= w_lane[QUO_W][i].quo;
        end
        for (int k = 1; k < ALIGN; k++) begin
            r_quo_dly[k] <= r_quo_dly[k-1];
        end
    end

    // Sign and zero case; the length is selected in the output register.
    always_comb begin
        v_last = r_meta[ROOT_W-1];
        v_root = w_root[ROOT_W];
        for (int i = 0; i < LANES; i++) begin
            if (v_last.zero) begin
                n_unit[i] = '0;
            end else if (v_last.neg[i]) begin
                n_unit[i] = ~UNIT_W'(r_quo_dly[ALIGN-1][i]) + UNIT_W'(1);
            end else begin
                n_unit[i] = UNIT_W'(r_quo_dly[ALIGN-1][i]);
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= v_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_vec_length  <= v_last.mode ? v_last.given : LEN_W'(v_root);
        o_unit_x      <= n_unit[0];
        o_unit_y      <= n_unit[1];
        o_unit_z      <= n_unit[2];
        o_zero_vector <= v_last.zero;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/v3n_checker.sv
`default_nettype none

module v3n_checker import v3n_pkg::*; (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire logic                      o_valid,
    input wire logic signed [UNIT_W-1:0]  o_unit_x,
    input wire logic signed [UNIT_W-1:0]  o_unit_y,
    input wire logic signed [UNIT_W-1:0]  o_unit_z,
    input wire logic                      o_zero_vector
);

    localparam logic signed [UNIT_W-1:0] ONE  = UNIT_W'(1) << (UNIT_W - 2);
    localparam int                       LAT  = 38;

    // Every transfer yields its result.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##38 o_valid)
        else $error("result missing after transfer");

    // No result without a transfer that caused it.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without transfer");

    // A zero vector reports a zero direction.
    a_zero_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_vector) |->
            (o_unit_x == '0 && o_unit_y == '0 && o_unit_z == '0))
        else $error("zero vector with nonzero direction");

    // Unit components never exceed one in magnitude.
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_unit_x <= ONE && o_unit_x >= -ONE
                  && o_unit_y <= ONE && o_unit_y >= -ONE
                  && o_unit_z <= ONE && o_unit_z >= -ONE))
        else $error("unit component out of range");

endmodule

bind vector3_normalize v3n_checker u_v3n_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_unit_x      (o_unit_x),
    .o_unit_y      (o_unit_y),
    .o_unit_z      (o_unit_z),
    .o_zero_vector (o_zero_vector)
);

`default_nettype wire
